[design/hmsu_pkg.sv]
// ----------------------------------------------------------------------------
// hmsu_pkg
// Shared types, codes and fixed-point helpers for the Heisenberg Metropolis
// spin update core.
// ----------------------------------------------------------------------------
package hmsu_pkg;

  localparam int SITES_DEF      = 1024;
  localparam int MAX_LINKS_DEF  = 8;
  localparam int FRAC_BITS      = 16;
  localparam int EXP_N          = 256;
  localparam int EXP_RANGE_LOG2 = 4;

  typedef enum logic [2:0] {
    OP_WRITE_SPIN  = 3'd0,
    OP_WRITE_SITE  = 3'd1,
    OP_WRITE_LINK  = 3'd2,
    OP_UPDATE      = 3'd3,
    OP_SET_ENERGY  = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPIN_WR,
    ST_LOAD,
    ST_DOT,
    ST_DOT_ACC,
    ST_REFL,
    ST_REFL_ACC,
    ST_ONS,
    ST_ONS_SQ,
    ST_ONS_D,
    ST_ONS_ACC,
    ST_LNK_RD,
    ST_LNK_NB,
    ST_LNK_SP,
    ST_LNK_J,
    ST_LNK_JT,
    ST_LNK_N,
    ST_LNK_ACC,
    ST_DEC,
    ST_EXPI,
    ST_DECIDE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [9:0]         site;
    logic [2:0]         link_slot;
    logic [9:0]         neighbor_site;
    logic [3:0]         link_total;
    logic signed [23:0] vec_x;
    logic signed [23:0] vec_y;
    logic signed [23:0] vec_z;
    logic [15:0]        uniform_random;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] delta_energy;
    logic signed [31:0] energy;
    logic signed [31:0] total_spin_x;
    logic signed [31:0] total_spin_y;
    logic signed [31:0] total_spin_z;
  } result_t;

  // round half up, then drop FRAC_BITS fraction bits
  function automatic logic signed [63:0] rs(input logic signed [63:0] v);
    logic signed [63:0] half;
    half = 64'sd1 <<< (FRAC_BITS - 1);
    return (v + half) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // exp(-16k/EXP_N) in Q1.16; evaluated at elaboration only
  function automatic logic [16:0] exp_entry(input int k);
    logic [63:0]        h;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        r;
    logic signed [63:0] sum;
    h    = (64'd1 << (32 + EXP_RANGE_LOG2)) / 64'(EXP_N);
    term = 64'd1 << 32;
    sum  = 64'sd1 <<< 32;
    for (int n = 1; n < 15; n++) begin
      term = ((term * h) >> 32) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    r = $unsigned(sum);
    e = 64'd1 << 32;
    for (int j = 0; j < k; j++) begin
      e = (e * r + (64'd1 << 31)) >> 32;
    end
    return 17'((e + 64'h8000) >> 16);
  endfunction

endpackage

[design/hmsu_ram.sv]
// ----------------------------------------------------------------------------
// hmsu_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hmsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/heisenberg_metropolis_spin_update_core.sv]
// ----------------------------------------------------------------------------
// heisenberg_metropolis_spin_update_core: local Metropolis update of a Heisenberg lattice
// Loads and updates are sequenced by a state machine, paced by one shared 35x25
// multiplier and one read port per state memory.
// One item at a time; the result register frees the input side once loaded.
// After reset a clearing pass over every site zeroes the spins and the link counts;
// no item before.
// ----------------------------------------------------------------------------
module heisenberg_metropolis_spin_update_core #(
  parameter int SITES     = hmsu_pkg::SITES_DEF,
  parameter int MAX_LINKS = hmsu_pkg::MAX_LINKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  hmsu_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output hmsu_pkg::result_t result
);

  localparam int SAW = $clog2(SITES);
  localparam int LCW = $clog2(MAX_LINKS + 1);
  localparam int LAW = $clog2(SITES * MAX_LINKS);
  localparam int IW  = $clog2(hmsu_pkg::EXP_N);
  localparam int SPW = 72;
  localparam int SRW = 72 + LCW;
  localparam int LRW = 82;

  hmsu_pkg::state_t state, state_next;
  hmsu_pkg::item_t  item_q;

  logic [SAW-1:0] clr;
  logic [1:0]     cnt;
  logic [LCW-1:0] lnk;
  logic [LCW-1:0] nl;

  logic signed [23:0] s_r  [3];
  logic signed [23:0] an_r [3];
  logic signed [23:0] nw_r [3];
  logic signed [23:0] jc_r [3];
  logic signed [23:0] ns_r [3];
  logic signed [24:0] t_r  [3];
  logic signed [23:0] dv   [3];

  logic signed [48:0] dot;
  logic signed [47:0] de;
  logic signed [31:0] sq;
  logic signed [32:0] jt;
  logic signed [31:0] dsat;
  logic               idx_ok;
  logic [IW-1:0]      idx;
  logic               acc_flag;

  logic signed [31:0] energy;
  logic signed [31:0] sum_x, sum_y, sum_z;

  logic signed [34:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [59:0] prod;

  logic signed [34:0] s1n;
  logic signed [23:0] nw_c;
  logic [43:0]        scaled;
  logic [43:0]        idx_full;
  logic               acc_now;
  logic               item_acc;
  logic               in_range;
  logic [LCW-1:0]     lc_in;
  logic               link_ok;
  logic [SAW-1:0]     site_q;

  logic           spin_we;
  logic [SAW-1:0] spin_waddr, spin_raddr;
  logic [SPW-1:0] spin_wdata, spin_rdata;
  logic           site_we;
  logic [SAW-1:0] site_waddr, site_raddr;
  logic [SRW-1:0] site_wdata, site_rdata;
  logic           link_we;
  logic [LAW-1:0] link_waddr, link_raddr;
  logic [LRW-1:0] link_wdata, link_rdata;

  logic [16:0] exp_tab [hmsu_pkg::EXP_N];

  for (genvar k = 0; k < hmsu_pkg::EXP_N; k++) begin : g_exp
    localparam logic [16:0] EV = hmsu_pkg::exp_entry(k);
    assign exp_tab[k] = EV;
  end

  hmsu_ram #(.WIDTH(SPW), .DEPTH(SITES)) u_spin_ram (
    .clk(clk), .we(spin_we), .waddr(spin_waddr), .wdata(spin_wdata),
    .raddr(spin_raddr), .rdata(spin_rdata)
  );

  hmsu_ram #(.WIDTH(SRW), .DEPTH(SITES)) u_site_ram (
    .clk(clk), .we(site_we), .waddr(site_waddr), .wdata(site_wdata),
    .raddr(site_raddr), .rdata(site_rdata)
  );

  hmsu_ram #(.WIDTH(LRW), .DEPTH(SITES * MAX_LINKS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  assign item_stall = (state != hmsu_pkg::ST_IDLE);
  assign item_acc   = item_valid && (state == hmsu_pkg::ST_IDLE);
  assign in_range   = 32'(item.site) < SITES;
  assign lc_in      = (32'(item.link_total) > MAX_LINKS) ? LCW'(MAX_LINKS)
                                                          : LCW'(item.link_total);
  assign link_ok    = (32'(item.link_slot) < MAX_LINKS) && (32'(item.neighbor_site) < SITES);
  assign site_q     = SAW'(item_q.site);

  assign dv[0] = item_q.vec_x;
  assign dv[1] = item_q.vec_y;
  assign dv[2] = item_q.vec_z;

  // reflection scale -2(s.d), magnitude stays well inside 35 bits
  assign s1n  = 35'(hmsu_pkg::rs(-(64'(dot) <<< 1)));
  assign nw_c = hmsu_pkg::sat24(64'(s_r[cnt]) + hmsu_pkg::rs(64'(prod)));

  assign scaled   = 44'($unsigned(dsat)) * 44'(hmsu_pkg::EXP_N);
  assign idx_full = scaled >> (hmsu_pkg::FRAC_BITS + hmsu_pkg::EXP_RANGE_LOG2);
  assign acc_now  = (dsat <= 32'sd0) ||
                    (idx_ok && (exp_tab[idx] > 17'(item_q.uniform_random)));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hmsu_pkg::ST_CLEAR: begin
        if (clr == SAW'(SITES - 1)) state_next = hmsu_pkg::ST_IDLE;
      end
      hmsu_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (!in_range) begin
            state_next = hmsu_pkg::ST_RESP;
          end else if (item.operation == hmsu_pkg::OP_WRITE_SPIN) begin
            state_next = hmsu_pkg::ST_SPIN_WR;
          end else if (item.operation == hmsu_pkg::OP_UPDATE) begin
            state_next = hmsu_pkg::ST_LOAD;
          end else begin
            state_next = hmsu_pkg::ST_RESP;
          end
        end
      end
      hmsu_pkg::ST_SPIN_WR:  state_next = hmsu_pkg::ST_RESP;
      hmsu_pkg::ST_LOAD:     state_next = hmsu_pkg::ST_DOT;
      hmsu_pkg::ST_DOT:      state_next = hmsu_pkg::ST_DOT_ACC;
      hmsu_pkg::ST_DOT_ACC:  state_next = (cnt == 2'd2) ? hmsu_pkg::ST_REFL : hmsu_pkg::ST_DOT;
      hmsu_pkg::ST_REFL:     state_next = hmsu_pkg::ST_REFL_ACC;
      hmsu_pkg::ST_REFL_ACC: state_next = (cnt == 2'd2) ? hmsu_pkg::ST_ONS : hmsu_pkg::ST_REFL;
      hmsu_pkg::ST_ONS:      state_next = hmsu_pkg::ST_ONS_SQ;
      hmsu_pkg::ST_ONS_SQ:   state_next = hmsu_pkg::ST_ONS_D;
      hmsu_pkg::ST_ONS_D:    state_next = hmsu_pkg::ST_ONS_ACC;
      hmsu_pkg::ST_ONS_ACC: begin
        if (cnt != 2'd2) begin
          state_next = hmsu_pkg::ST_ONS;
        end else if (nl == '0) begin
          state_next = hmsu_pkg::ST_DEC;
        end else begin
          state_next = hmsu_pkg::ST_LNK_RD;
        end
      end
      hmsu_pkg::ST_LNK_RD:   state_next = hmsu_pkg::ST_LNK_NB;
      hmsu_pkg::ST_LNK_NB:   state_next = hmsu_pkg::ST_LNK_SP;
      hmsu_pkg::ST_LNK_SP:   state_next = hmsu_pkg::ST_LNK_J;
      hmsu_pkg::ST_LNK_J:    state_next = hmsu_pkg::ST_LNK_JT;
      hmsu_pkg::ST_LNK_JT:   state_next = hmsu_pkg::ST_LNK_N;
      hmsu_pkg::ST_LNK_N:    state_next = hmsu_pkg::ST_LNK_ACC;
      hmsu_pkg::ST_LNK_ACC: begin
        if (cnt != 2'd2) begin
          state_next = hmsu_pkg::ST_LNK_J;
        end else if (LCW'(lnk + 1'b1) == nl) begin
          state_next = hmsu_pkg::ST_DEC;
        end else begin
          state_next = hmsu_pkg::ST_LNK_RD;
        end
      end
      hmsu_pkg::ST_DEC:      state_next = hmsu_pkg::ST_EXPI;
      hmsu_pkg::ST_EXPI:     state_next = hmsu_pkg::ST_DECIDE;
      hmsu_pkg::ST_DECIDE:   state_next = hmsu_pkg::ST_RESP;
      hmsu_pkg::ST_RESP: begin
        if (!result_valid || !result_stall) state_next = hmsu_pkg::ST_IDLE;
      end
      default: state_next = hmsu_pkg::ST_IDLE;
    endcase
  end

  // memory control and multiplier operands
  always_comb begin
    spin_we    = 1'b0;
    spin_waddr = site_q;
    spin_wdata = {item_q.vec_x, item_q.vec_y, item_q.vec_z};
    spin_raddr = SAW'(item.site);
    site_we    = 1'b0;
    site_waddr = SAW'(item.site);
    site_wdata = {item.vec_x, item.vec_y, item.vec_z, lc_in};
    site_raddr = SAW'(item.site);
    link_we    = 1'b0;
    link_waddr = LAW'(32'(item.site) * MAX_LINKS + 32'(item.link_slot));
    link_wdata = {item.neighbor_site, item.vec_x, item.vec_y, item.vec_z};
    link_raddr = LAW'(32'(site_q) * MAX_LINKS + 32'(lnk));
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      hmsu_pkg::ST_CLEAR: begin
        site_we    = 1'b1;
        site_waddr = clr;
        site_wdata = '0;
        spin_we    = 1'b1;
        spin_waddr = clr;
        spin_wdata = '0;
      end
      hmsu_pkg::ST_IDLE: begin
        if (item_acc && in_range) begin
          site_we = (item.operation == hmsu_pkg::OP_WRITE_SITE);
          link_we = (item.operation == hmsu_pkg::OP_WRITE_LINK) && link_ok;
        end
      end
      hmsu_pkg::ST_SPIN_WR: spin_we = 1'b1;
      hmsu_pkg::ST_DOT: begin
        mul_a = 35'(s_r[cnt]);
        mul_b = 25'(dv[cnt]);
      end
      hmsu_pkg::ST_REFL: begin
        mul_a = s1n;
        mul_b = 25'(dv[cnt]);
      end
      hmsu_pkg::ST_ONS: begin
        // s'^2 - s^2 as (s' - s)(s' + s)
        mul_a = 35'(t_r[cnt]);
        mul_b = 25'(nw_r[cnt]) + 25'(s_r[cnt]);
      end
      hmsu_pkg::ST_ONS_D: begin
        mul_a = 35'(sq);
        mul_b = 25'(an_r[cnt]);
      end
      hmsu_pkg::ST_LNK_NB: spin_raddr = SAW'(link_rdata[81:72]);
      hmsu_pkg::ST_LNK_J: begin
        mul_a = 35'(jc_r[cnt]);
        mul_b = t_r[cnt];
      end
      hmsu_pkg::ST_LNK_N: begin
        mul_a = 35'(jt);
        mul_b = 25'(ns_r[cnt]);
      end
      hmsu_pkg::ST_DECIDE: begin
        spin_we    = acc_now;
        spin_wdata = {nw_r[0], nw_r[1], nw_r[2]};
      end
      default: begin
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hmsu_pkg::ST_CLEAR;
      clr          <= '0;
      cnt          <= '0;
      lnk          <= '0;
      result_valid <= 1'b0;
      energy       <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
    end else begin
      state <= state_next;
      case (state)
        hmsu_pkg::ST_CLEAR: clr <= clr + 1'b1;
        hmsu_pkg::ST_IDLE: begin
          if (item_acc && in_range && item.operation == hmsu_pkg::OP_SET_ENERGY) begin
            energy <= 32'(item.vec_x);
          end
        end
        hmsu_pkg::ST_SPIN_WR: begin
          sum_x <= hmsu_pkg::sat32(64'(sum_x) + 64'(item_q.vec_x)
                                   - 64'($signed(spin_rdata[71:48])));
          sum_y <= hmsu_pkg::sat32(64'(sum_y) + 64'(item_q.vec_y)
                                   - 64'($signed(spin_rdata[47:24])));
          sum_z <= hmsu_pkg::sat32(64'(sum_z) + 64'(item_q.vec_z)
                                   - 64'($signed(spin_rdata[23:0])));
        end
        hmsu_pkg::ST_LOAD: cnt <= '0;
        hmsu_pkg::ST_DOT_ACC, hmsu_pkg::ST_REFL_ACC: begin
          cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 1'b1;
        end
        hmsu_pkg::ST_ONS_ACC: begin
          cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 1'b1;
          lnk <= '0;
        end
        hmsu_pkg::ST_LNK_ACC: begin
          cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 1'b1;
          if (cnt == 2'd2) lnk <= lnk + 1'b1;
        end
        hmsu_pkg::ST_DECIDE: begin
          if (acc_now) begin
            sum_x  <= hmsu_pkg::sat32(64'(sum_x) + 64'(t_r[0]));
            sum_y  <= hmsu_pkg::sat32(64'(sum_y) + 64'(t_r[1]));
            sum_z  <= hmsu_pkg::sat32(64'(sum_z) + 64'(t_r[2]));
            energy <= hmsu_pkg::sat32(64'(energy) + 64'(de));
          end
        end
        default: begin
        end
      endcase
      if (state == hmsu_pkg::ST_RESP && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      hmsu_pkg::ST_IDLE: begin
        if (item_acc) begin
          item_q   <= item;
          acc_flag <= 1'b0;
          dsat     <= '0;
        end
      end
      hmsu_pkg::ST_LOAD: begin
        s_r[0]  <= $signed(spin_rdata[71:48]);
        s_r[1]  <= $signed(spin_rdata[47:24]);
        s_r[2]  <= $signed(spin_rdata[23:0]);
        an_r[0] <= $signed(site_rdata[SRW-1:SRW-24]);
        an_r[1] <= $signed(site_rdata[SRW-25:SRW-48]);
        an_r[2] <= $signed(site_rdata[SRW-49:SRW-72]);
        nl      <= site_rdata[LCW-1:0];
        dot     <= '0;
        de      <= '0;
      end
      hmsu_pkg::ST_DOT_ACC: dot <= dot + 49'(prod);
      hmsu_pkg::ST_REFL_ACC: begin
        nw_r[cnt] <= nw_c;
        t_r[cnt]  <= 25'(nw_c) - 25'(s_r[cnt]);
      end
      hmsu_pkg::ST_ONS_SQ: sq <= 32'(hmsu_pkg::rs(64'(prod)));
      hmsu_pkg::ST_ONS_ACC, hmsu_pkg::ST_LNK_ACC: begin
        de <= de + 48'(hmsu_pkg::rs(64'(prod)));
      end
      hmsu_pkg::ST_LNK_NB: begin
        jc_r[0] <= $signed(link_rdata[71:48]);
        jc_r[1] <= $signed(link_rdata[47:24]);
        jc_r[2] <= $signed(link_rdata[23:0]);
      end
      hmsu_pkg::ST_LNK_SP: begin
        // self links see the spin from before the move: nothing is written yet
        ns_r[0] <= $signed(spin_rdata[71:48]);
        ns_r[1] <= $signed(spin_rdata[47:24]);
        ns_r[2] <= $signed(spin_rdata[23:0]);
      end
      hmsu_pkg::ST_LNK_JT: jt <= 33'(hmsu_pkg::rs(64'(prod)));
      hmsu_pkg::ST_DEC: dsat <= hmsu_pkg::sat32(64'(de));
      hmsu_pkg::ST_EXPI: begin
        idx_ok <= (dsat > 32'sd0) && (idx_full < 44'(hmsu_pkg::EXP_N));
        idx    <= IW'(idx_full);
      end
      hmsu_pkg::ST_DECIDE: acc_flag <= acc_now;
      default: begin
      end
    endcase
    if (state == hmsu_pkg::ST_RESP && (!result_valid || !result_stall)) begin
      result.accepted     <= acc_flag;
      result.delta_energy <= dsat;
      result.energy       <= energy;
      result.total_spin_x <= sum_x;
      result.total_spin_y <= sum_y;
      result.total_spin_z <= sum_z;
    end
  end

endmodule

[verif/heisenberg_metropolis_spin_update_checker.sv]
// ----------------------------------------------------------------------------
// heisenberg_metropolis_spin_update_checker
// Watches both channels of the spin update core, keeps its own copy of the
// lattice state, works out each result and compares it field by field.
// ----------------------------------------------------------------------------
module heisenberg_metropolis_spin_update_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  hmsu_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  hmsu_pkg::result_t result,
  output int                mismatches,
  output int                pending,
  output int                results_seen,
  output int                updates_seen,
  output int                moves_taken
);
  import hmsu_pkg::*;

  logic signed [23:0] spin_mem  [0:1023][0:2];
  logic signed [23:0] aniso_mem [0:1023][0:2];
  logic [3:0]         nlinks_mem[0:1023];
  logic [9:0]         nbr_mem   [0:8191];
  logic signed [23:0] cpl_mem   [0:8191][0:2];
  logic signed [31:0] energy_q;
  logic signed [31:0] sum_q [0:2];
  logic [16:0]        boltz_lut [0:EXP_N-1];
  result_t            expected_q[$];

  function automatic longint round_q(input longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint clip24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Boltzmann factor table: Taylor series for one step, then repeated products
  initial begin
    longint unsigned h, term, e, r;
    longint          acc;
    h    = (64'd1 << (32 + EXP_RANGE_LOG2)) / EXP_N;
    term = 64'd1 << 32;
    acc  = 64'sd1 <<< 32;
    for (int n = 1; n < 15; n++) begin
      term = ((term * h) >> 32) / n;
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    r = acc;
    e = 64'd1 << 32;
    for (int k = 0; k < EXP_N; k++) begin
      boltz_lut[k] = 17'((e + 64'h8000) >> 16);
      e = (e * r + (64'd1 << 31)) >> 32;
    end
  end

  function automatic result_t next_lattice_result(input item_t it);
    result_t            res;
    longint             vv[3], s[3], nw[3], t[3];
    longint             dot, s1n, de, jt, sq, idx;
    logic signed [31:0] dsat;
    logic [12:0]        li;
    logic [9:0]         nb;
    logic               take;
    vv[0] = it.vec_x;
    vv[1] = it.vec_y;
    vv[2] = it.vec_z;
    dsat  = '0;
    take  = 1'b0;
    case (it.operation)
      OP_WRITE_SPIN: begin
        for (int c = 0; c < 3; c++) begin
          sum_q[c] = clip32(longint'(sum_q[c]) + vv[c] - longint'(spin_mem[it.site][c]));
          spin_mem[it.site][c] = vv[c][23:0];
        end
      end
      OP_WRITE_SITE: begin
        for (int c = 0; c < 3; c++) aniso_mem[it.site][c] = vv[c][23:0];
        nlinks_mem[it.site] = (it.link_total > 4'd8) ? 4'd8 : it.link_total;
      end
      OP_WRITE_LINK: begin
        li = {it.site, it.link_slot};
        nbr_mem[li] = it.neighbor_site;
        for (int c = 0; c < 3; c++) cpl_mem[li][c] = vv[c][23:0];
      end
      OP_SET_ENERGY: energy_q = clip32(vv[0]);
      OP_UPDATE: begin
        dot = 0;
        de  = 0;
        for (int c = 0; c < 3; c++) begin
          s[c] = spin_mem[it.site][c];
          dot += s[c] * vv[c];
        end
        s1n = round_q(-2 * dot);
        if (s1n > (64'sd1 <<< 38)) s1n = 64'sd1 <<< 38;
        if (s1n < -(64'sd1 <<< 38)) s1n = -(64'sd1 <<< 38);
        for (int c = 0; c < 3; c++) begin
          nw[c] = clip24(s[c] + round_q(vv[c] * s1n));
          t[c]  = nw[c] - s[c];
        end
        for (int i = 0; i < nlinks_mem[it.site]; i++) begin
          li = {it.site, 3'(i)};
          nb = nbr_mem[li];
          for (int c = 0; c < 3; c++) begin
            jt  = round_q(longint'(cpl_mem[li][c]) * t[c]);
            de += round_q(jt * longint'(spin_mem[nb][c]));
          end
        end
        for (int c = 0; c < 3; c++) begin
          sq  = round_q(nw[c] * nw[c] - s[c] * s[c]);
          de += round_q(longint'(aniso_mem[it.site][c]) * sq);
        end
        dsat = clip32(de);
        if (dsat <= 0) begin
          take = 1'b1;
        end else begin
          idx = (longint'(dsat) * EXP_N) >>> (FRAC_BITS + EXP_RANGE_LOG2);
          take = (idx < EXP_N) && (boltz_lut[idx] > it.uniform_random);
        end
        if (take) begin
          for (int c = 0; c < 3; c++) begin
            spin_mem[it.site][c] = nw[c][23:0];
            sum_q[c] = clip32(longint'(sum_q[c]) + t[c]);
          end
          energy_q = clip32(longint'(energy_q) + de);
        end
      end
      default: ;
    endcase
    res.accepted     = take;
    res.delta_energy = dsat;
    res.energy       = energy_q;
    res.total_spin_x = sum_q[0];
    res.total_spin_y = sum_q[1];
    res.total_spin_z = sum_q[2];
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < 1024; i++) begin
        nlinks_mem[i] = '0;
        for (int c = 0; c < 3; c++) begin
          spin_mem[i][c]  = '0;
          aniso_mem[i][c] = '0;
        end
      end
      for (int i = 0; i < 8192; i++) begin
        nbr_mem[i] = '0;
        for (int c = 0; c < 3; c++) cpl_mem[i][c] = '0;
      end
      energy_q = '0;
      for (int c = 0; c < 3; c++) sum_q[c] = '0;
      expected_q.delete();
      mismatches   <= 0;
      results_seen <= 0;
      updates_seen <= 0;
      moves_taken  <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        want = next_lattice_result(item);
        expected_q.push_back(want);
        if (item.operation == OP_UPDATE) updates_seen <= updates_seen + 1;
      end
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("ERROR: unexpected result transaction %p", result);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (result.accepted) moves_taken <= moves_taken + 1;
          if (result.accepted !== want.accepted || result.delta_energy !== want.delta_energy ||
              result.energy !== want.energy || result.total_spin_x !== want.total_spin_x ||
              result.total_spin_y !== want.total_spin_y ||
              result.total_spin_z !== want.total_spin_z) begin
            if (mismatches < 10) begin
              $display("ERROR: result mismatch at %0t", $realtime);
              $display("  expected acc=%0d dE=%0d E=%0d S=(%0d,%0d,%0d)", want.accepted,
                       want.delta_energy, want.energy, want.total_spin_x,
                       want.total_spin_y, want.total_spin_z);
              $display("  actual   acc=%0d dE=%0d E=%0d S=(%0d,%0d,%0d)", result.accepted,
                       result.delta_energy, result.energy, result.total_spin_x,
                       result.total_spin_y, result.total_spin_z);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

[verif/heisenberg_metropolis_spin_update_core_tb.sv]
// ----------------------------------------------------------------------------
// heisenberg_metropolis_spin_update_core_tb
// Loads a small lattice, runs directed corner cases and then random loads and
// Metropolis updates with random idling and one long output hold-off.
// ----------------------------------------------------------------------------
module heisenberg_metropolis_spin_update_core_tb;
  import hmsu_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int POOL_N     = 8;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      mismatches, pending, results_seen, updates_seen, moves_taken;
  bit      quiet;
  int      idle_cycles;
  logic [9:0] pool [POOL_N];

  heisenberg_metropolis_spin_update_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  heisenberg_metropolis_spin_update_checker lattice_chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen),
    .updates_seen(updates_seen), .moves_taken(moves_taken)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // components mostly within +/-1.0, sometimes anything, sometimes the rails
  function automatic logic signed [23:0] rnd_comp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 24'($signed($urandom_range(0, 131072)) - 65536);
    if (pick < 90) return 24'($urandom);
    return (pick < 95) ? 24'sh7FFFFF : 24'sh800000;
  endfunction

  function automatic item_t mk(input logic [2:0] op, input logic [9:0] st,
                               input logic [2:0] slot, input logic [9:0] nb,
                               input logic [3:0] lt, input logic signed [23:0] x,
                               input logic signed [23:0] y, input logic signed [23:0] z);
    item_t        it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(item_t)-1:0];
    it.operation     = op;
    it.site          = st;
    it.link_slot     = slot;
    it.neighbor_site = nb;
    it.link_total    = lt;
    it.vec_x         = x;
    it.vec_y         = y;
    it.vec_z         = z;
    return it;
  endfunction

  function automatic bit in_pool(input logic [9:0] st);
    foreach (pool[k]) if (pool[k] == st) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [9:0] any_pool();
    return pool[$urandom_range(POOL_N - 1)];
  endfunction

  task automatic send(input item_t it);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (!quiet && $urandom_range(99) < 32) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // receiver: random stalls, plus one long hold-off once traffic is flowing
  initial begin
    bit held;
    held = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 120) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        result_stall <= !quiet && ($urandom_range(99) < 32);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    item_t it;
    int    pick;
    logic [9:0] st;
    quiet      = 1'b0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    pool[0] = 10'd0;
    pool[1] = 10'd1023;
    for (int k = 2; k < POOL_N; k++) pool[k] = 10'((k - 1) * 128 + $urandom_range(1, 120));

    // fully populate the site pool before any update
    foreach (pool[k]) begin
      send(mk(OP_WRITE_SPIN, pool[k], 0, 0, 0, rnd_comp(), rnd_comp(), rnd_comp()));
      send(mk(OP_WRITE_SITE, pool[k], 0, 0, 4'd8, rnd_comp(), rnd_comp(), rnd_comp()));
      for (int j = 0; j < 8; j++)
        send(mk(OP_WRITE_LINK, pool[k], 3'(j), any_pool(), 0,
                rnd_comp(), rnd_comp(), rnd_comp()));
    end

    // directed corners
    send(mk(OP_SET_ENERGY, 0, 0, 0, 0, 24'sh7FFFFF, 0, 0));
    send(mk(OP_SET_ENERGY, 0, 0, 0, 0, 24'sh800000, 0, 0));
    send(mk(3'd5, pool[2], 0, 0, 0, 24'sh7FFFFF, 1, 1));
    send(mk(3'd6, pool[3], 0, 0, 0, 1, 1, 1));
    send(mk(3'd7, pool[4], 0, 0, 0, 1, 1, 1));
    send(mk(OP_WRITE_SITE, pool[1], 0, 0, 4'd15, 24'sh10000, 24'sh10000, 24'sh800000));
    send(mk(OP_WRITE_LINK, pool[2], 3'd0, pool[2], 0, 24'sh10000, 24'sh10000, 24'sh10000));
    send(mk(OP_WRITE_SITE, pool[2], 0, 0, 4'd0, 0, 0, 0));
    it = mk(OP_UPDATE, pool[2], 0, 0, 0, 24'sh10000, 0, 0);
    it.uniform_random = 16'd0;
    send(it);
    send(mk(OP_WRITE_SITE, pool[2], 0, 0, 4'd1, 24'sh8000, 24'sh8000, 24'sh8000));
    it = mk(OP_UPDATE, pool[2], 0, 0, 0, 0, 24'sh10000, 0);
    it.uniform_random = 16'hFFFF;
    send(it);
    send(mk(OP_WRITE_SPIN, pool[3], 0, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
    send(mk(OP_UPDATE, pool[3], 0, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
    send(mk(OP_UPDATE, pool[3], 0, 0, 0, 24'sh800000, 24'sh800000, 24'sh800000));
    send(mk(OP_UPDATE, pool[0], 0, 0, 0, 0, 0, 0));
    send(mk(OP_WRITE_SPIN, pool[3], 0, 0, 0, 24'sh800000, 24'sh800000, 24'sh800000));
    send(mk(OP_UPDATE, pool[1], 0, 0, 0, 24'sh10000, 0, 0));
    send(mk(OP_SET_ENERGY, 0, 0, 0, 0, 0, 0, 0));

    for (int n = 0; n < 300; n++) begin
      quiet = (n >= 150 && n < 230);
      pick  = $urandom_range(99);
      if (pick < 45) begin
        it = mk(OP_UPDATE, any_pool(), 0, 0, 0, rnd_comp(), rnd_comp(), rnd_comp());
      end else if (pick < 58) begin
        it = mk(OP_WRITE_SPIN, any_pool(), 0, 0, 0, rnd_comp(), rnd_comp(), rnd_comp());
      end else if (pick < 65) begin
        it = mk(OP_WRITE_SPIN, 10'($urandom), 0, 0, 0, 24'($urandom), 24'($urandom),
                24'($urandom));
      end else if (pick < 75) begin
        st = ($urandom_range(1)) ? any_pool() : 10'($urandom);
        it = mk(OP_WRITE_SITE, st, 0, 0, 4'($urandom), rnd_comp(), rnd_comp(), rnd_comp());
      end else if (pick < 88) begin
        st = ($urandom_range(1)) ? any_pool() : 10'($urandom);
        it = mk(OP_WRITE_LINK, st, 3'($urandom), in_pool(st) ? any_pool() : 10'($urandom),
                0, rnd_comp(), rnd_comp(), rnd_comp());
      end else if (pick < 94) begin
        it = mk(OP_SET_ENERGY, 10'($urandom), 0, 0, 0, 24'($urandom), 0, 0);
      end else begin
        it = mk(3'($urandom_range(5, 7)), 10'($urandom), 0, 0, 0, 24'($urandom),
                24'($urandom), 24'($urandom));
      end
      send(it);
    end
    item_valid <= 1'b0;
    quiet = 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Checked %0d result transactions: %0d Metropolis updates, %0d moves taken.",
             results_seen, updates_seen, moves_taken);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/hmsu_pkg.sv
design/hmsu_ram.sv
design/heisenberg_metropolis_spin_update_core.sv
verif/heisenberg_metropolis_spin_update_checker.sv
verif/heisenberg_metropolis_spin_update_core_tb.sv
